/* hdl/ibt_pkg.sv */
// ----------------------------------------------------------------------------
// ibt_pkg
// Shared types and constants of the region-of-interest tracking table.
// ----------------------------------------------------------------------------
package ibt_pkg;

  localparam int COORD_BITS    = 12;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int FRAME_BITS    = 13;
  localparam int PAD_BITS      = 8;
  localparam int LIMIT_BITS    = 8;
  localparam int COUNT_BITS    = 8;
  localparam int IDENT_BITS    = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 13;

  // arithmetic widths
  localparam int CLAMP_BITS = COORD_BITS + 3;      // padded coordinate, signed
  localparam int DIFF_BITS  = COORD_BITS + 1;      // x2 - x1, signed
  localparam int AREA_BITS  = 2 * COORD_BITS + 2;  // signed box area
  localparam int INTER_BITS = 2 * COORD_BITS;      // unsigned overlap area
  localparam int SUM_BITS   = 2 * COORD_BITS + 4;  // union and 5 * intersection

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_PADDING   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HISTORY_LIMIT = 3'd3;

  localparam logic [PAD_BITS-1:0]   BOX_PADDING_RST   = 8'd0;
  localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RST   = 13'd640;
  localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RST  = 13'd480;
  localparam logic [LIMIT_BITS-1:0] HISTORY_LIMIT_RST = 8'd10;

  // operation codes
  localparam logic OP_TICK      = 1'b0;
  localparam logic OP_CANDIDATE = 1'b1;

  localparam logic [COUNT_BITS-1:0] COUNT_STEP = 8'd2;
  localparam logic [COUNT_BITS-1:0] COUNT_NEW  = 8'd1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } box_t;

  typedef struct packed {
    logic [IDENT_BITS-1:0] ident;
    logic [COUNT_BITS-1:0] count;
    box_t                  box;
  } entry_t;

  typedef struct packed {
    logic   op;
    coord_t near_x;
    coord_t near_y;
    coord_t far_x;
    coord_t far_y;
  } in_item_t;

  typedef struct packed {
    logic [IDENT_BITS-1:0] region_id;
    logic                  matched;
    logic                  table_full;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } iou_status_t;

endpackage

/* hdl/ibt_box_prep.sv */
// ----------------------------------------------------------------------------
// ibt_box_prep
// Pads the near and far points outward and clamps them into the frame.
// ----------------------------------------------------------------------------
module ibt_box_prep (
  input  ibt_pkg::in_item_t                 item,
  input  logic [ibt_pkg::PAD_BITS-1:0]      pad,
  input  logic [ibt_pkg::FRAME_BITS-1:0]    frame_w,
  input  logic [ibt_pkg::FRAME_BITS-1:0]    frame_h,
  output ibt_pkg::box_t                     box
);

  function automatic ibt_pkg::coord_t clamp_coord(
    input logic signed [ibt_pkg::CLAMP_BITS-1:0] v,
    input logic [ibt_pkg::FRAME_BITS-1:0]        size
  );
    logic [ibt_pkg::FRAME_BITS-1:0]        szm1;
    logic signed [ibt_pkg::CLAMP_BITS-1:0] hi;
    logic signed [ibt_pkg::CLAMP_BITS-1:0] r;
    szm1 = size - ibt_pkg::FRAME_BITS'(1);
    if (szm1 > ibt_pkg::FRAME_BITS'(ibt_pkg::COORD_MAX)) begin
      hi = ibt_pkg::CLAMP_BITS'(ibt_pkg::COORD_MAX);
    end else begin
      hi = $signed(ibt_pkg::CLAMP_BITS'(szm1));
    end
    // empty frame clamps everything to zero
    if (size == '0) begin
      r = '0;
    end else if (v > hi) begin
      r = hi;
    end else if (v < 0) begin
      r = '0;
    end else begin
      r = v;
    end
    return r[ibt_pkg::COORD_BITS-1:0];
  endfunction

  logic signed [ibt_pkg::CLAMP_BITS-1:0] pad_s;
  logic signed [ibt_pkg::CLAMP_BITS-1:0] x1_s, y1_s, x2_s, y2_s;

  always_comb begin
    pad_s = $signed(ibt_pkg::CLAMP_BITS'(pad));
    x1_s  = $signed(ibt_pkg::CLAMP_BITS'(item.near_x)) - pad_s;
    y1_s  = $signed(ibt_pkg::CLAMP_BITS'(item.near_y)) - pad_s;
    x2_s  = $signed(ibt_pkg::CLAMP_BITS'(item.far_x)) + pad_s;
    y2_s  = $signed(ibt_pkg::CLAMP_BITS'(item.far_y)) + pad_s;
    box.x1 = clamp_coord(x1_s, frame_w);
    box.y1 = clamp_coord(y1_s, frame_h);
    box.x2 = clamp_coord(x2_s, frame_w);
    box.y2 = clamp_coord(y2_s, frame_h);
  end

endmodule

/* hdl/ibt_iou_unit.sv */
// ----------------------------------------------------------------------------
// ibt_iou_unit
// Two-stage overlap test of one stored entry per cycle against the candidate.
// ----------------------------------------------------------------------------
module ibt_iou_unit #(
  parameter int ADDR_BITS = 4
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     flush,
  input  logic                                     in_valid,
  input  logic [ADDR_BITS-1:0]                     in_idx,
  input  ibt_pkg::entry_t                          in_entry,
  input  ibt_pkg::box_t                            cand_box,
  input  logic signed [ibt_pkg::AREA_BITS-1:0]     cand_area,
  output ibt_pkg::iou_status_t                     status,
  output logic [ADDR_BITS-1:0]                     hit_idx,
  output logic [ibt_pkg::IDENT_BITS-1:0]           hit_ident,
  output logic [ibt_pkg::COUNT_BITS-1:0]           hit_count
);

  ibt_pkg::coord_t                       lx, ly, hx, hy, dx, dy;
  logic signed [ibt_pkg::DIFF_BITS-1:0]  ex, ey;

  // stage 1: overlap extents and entry sides
  logic                                  s1_v_r;
  logic [ADDR_BITS-1:0]                  s1_idx_r;
  logic [ibt_pkg::IDENT_BITS-1:0]        s1_ident_r;
  logic [ibt_pkg::COUNT_BITS-1:0]        s1_count_r;
  ibt_pkg::coord_t                       s1_dx_r, s1_dy_r;
  logic signed [ibt_pkg::DIFF_BITS-1:0]  s1_ex_r, s1_ey_r;

  // stage 2: products
  logic                                  s2_v_r;
  logic [ADDR_BITS-1:0]                  s2_idx_r;
  logic [ibt_pkg::IDENT_BITS-1:0]        s2_ident_r;
  logic [ibt_pkg::COUNT_BITS-1:0]        s2_count_r;
  logic [ibt_pkg::INTER_BITS-1:0]        s2_inter_r;
  logic signed [ibt_pkg::AREA_BITS-1:0]  s2_area_r;

  logic signed [ibt_pkg::SUM_BITS-1:0]   inter_s, uni, five;

  always_comb begin
    lx = (in_entry.box.x1 > cand_box.x1) ? in_entry.box.x1 : cand_box.x1;
    ly = (in_entry.box.y1 > cand_box.y1) ? in_entry.box.y1 : cand_box.y1;
    hx = (in_entry.box.x2 < cand_box.x2) ? in_entry.box.x2 : cand_box.x2;
    hy = (in_entry.box.y2 < cand_box.y2) ? in_entry.box.y2 : cand_box.y2;
    dx = (hx > lx) ? hx - lx : '0;
    dy = (hy > ly) ? hy - ly : '0;
    ex = $signed({1'b0, in_entry.box.x2}) - $signed({1'b0, in_entry.box.x1});
    ey = $signed({1'b0, in_entry.box.y2}) - $signed({1'b0, in_entry.box.y1});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid && !flush;
      s2_v_r <= s1_v_r && !flush;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r   <= in_idx;
    s1_ident_r <= in_entry.ident;
    s1_count_r <= in_entry.count;
    s1_dx_r    <= dx;
    s1_dy_r    <= dy;
    s1_ex_r    <= ex;
    s1_ey_r    <= ey;
    s2_idx_r   <= s1_idx_r;
    s2_ident_r <= s1_ident_r;
    s2_count_r <= s1_count_r;
    s2_inter_r <= s1_dx_r * s1_dy_r;
    s2_area_r  <= s1_ex_r * s1_ey_r;
  end

  // IoU > 0.2 exactly: union > 0 and 5 * intersection > union
  always_comb begin
    inter_s = $signed(ibt_pkg::SUM_BITS'(s2_inter_r));
    uni     = ibt_pkg::SUM_BITS'(s2_area_r) + ibt_pkg::SUM_BITS'(cand_area) - inter_s;
    five    = (inter_s <<< 2) + inter_s;
    status.busy = s1_v_r || s2_v_r;
    status.hit  = s2_v_r && (uni > 0) && (five > uni);
  end

  assign hit_idx   = s2_idx_r;
  assign hit_ident = s2_ident_r;
  assign hit_count = s2_count_r;

endmodule

/* hdl/iou_box_track_table.sv */
// ----------------------------------------------------------------------------
// iou_box_track_table
// Table of tracked boxes matched by IoU, held in one synchronous entry RAM.
// ----------------------------------------------------------------------------
//  channel | ports                           | transfer
//  --------+---------------------------------+--------------------------------
//  input   | start, busy, in_data            | start && !busy
//  result  | out_valid, out_data             | out_valid, one cycle, no stall
//  config  | cfg_we, cfg_idx, cfg_wdata      | cfg_we, write only
//
//  Frame tick: one RAM read-modify-write per filled entry. Candidate: padding,
//  area set-up, one read per cycle through the two-stage IoU unit until a hit,
//  write-back. The result is registered in the cycle after write-back.
//  Synchronous reset (rst_n low) empties the table; RAM content is not cleared.
//  The result side cannot stall; busy alone holds off new transactions.
// ----------------------------------------------------------------------------
module iou_box_track_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  ibt_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  output ibt_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [ibt_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
  input  logic [ibt_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_TICK = 6'b000010,
    ST_PREP = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_INS  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [ibt_pkg::PAD_BITS-1:0]   pad_r;
  logic [ibt_pkg::FRAME_BITS-1:0] frame_w_r, frame_h_r;
  logic [ibt_pkg::LIMIT_BITS-1:0] limit_r;

  logic [CW-1:0]                  fill_r;
  logic [ibt_pkg::IDENT_BITS-1:0] highest_r;
  logic [CW-1:0]                  iss_r;
  logic                           rv0_r;
  logic [AW-1:0]                  ra0_r;

  ibt_pkg::box_t                         prep_box, cand_box_r;
  logic signed [ibt_pkg::DIFF_BITS-1:0]  cand_dx, cand_dy;
  logic signed [ibt_pkg::AREA_BITS-1:0]  cand_area_r;

  logic [AW-1:0]                  m_idx_r;
  logic [ibt_pkg::IDENT_BITS-1:0] m_ident_r;
  logic [ibt_pkg::COUNT_BITS-1:0] m_count_r;

  logic                           out_valid_r;
  ibt_pkg::out_item_t             out_data_r;

  // entry RAM
  ibt_pkg::entry_t mem [TABLE_DEPTH];
  ibt_pkg::entry_t rd_q;
  logic [AW-1:0]   rd_addr;
  logic            we;
  logic [AW-1:0]   wa;
  ibt_pkg::entry_t wd;

  ibt_pkg::iou_status_t           iou_st;
  logic [AW-1:0]                  hit_idx;
  logic [ibt_pkg::IDENT_BITS-1:0] hit_ident;
  logic [ibt_pkg::COUNT_BITS-1:0] hit_count;

  logic                            accept, issue, more, full;
  logic [ibt_pkg::COUNT_BITS:0]    sat_sum;
  logic [ibt_pkg::COUNT_BITS-1:0]  sat_count;
  logic [ibt_pkg::IDENT_BITS-1:0]  id_inc, new_id;

  ibt_box_prep u_prep (
    .item    (in_data),
    .pad     (pad_r),
    .frame_w (frame_w_r),
    .frame_h (frame_h_r),
    .box     (prep_box)
  );

  ibt_iou_unit #(
    .ADDR_BITS (AW)
  ) u_iou (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (state_r != ST_SCAN),
    .in_valid  (rv0_r && (state_r == ST_SCAN)),
    .in_idx    (ra0_r),
    .in_entry  (rd_q),
    .cand_box  (cand_box_r),
    .cand_area (cand_area_r),
    .status    (iou_st),
    .hit_idx   (hit_idx),
    .hit_ident (hit_ident),
    .hit_count (hit_count)
  );

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign more    = (iss_r < fill_r);
  assign full    = (fill_r == CW'(TABLE_DEPTH));
  assign rd_addr = iss_r[AW-1:0];

  always_comb begin
    unique case (state_r)
      ST_TICK: issue = more;
      ST_SCAN: issue = more && !iou_st.hit;
      default: issue = 1'b0;
    endcase
  end

  always_comb begin
    cand_dx   = $signed({1'b0, cand_box_r.x2}) - $signed({1'b0, cand_box_r.x1});
    cand_dy   = $signed({1'b0, cand_box_r.y2}) - $signed({1'b0, cand_box_r.y1});
    sat_sum   = {1'b0, m_count_r} + {1'b0, ibt_pkg::COUNT_STEP};
    sat_count = (sat_sum > {1'b0, limit_r}) ? limit_r : sat_sum[ibt_pkg::COUNT_BITS-1:0];
    id_inc    = highest_r + ibt_pkg::IDENT_BITS'(1);
    // id zero is reserved for the full answer
    new_id    = (id_inc == '0) ? ibt_pkg::IDENT_BITS'(1) : id_inc;
  end

  // RAM write port
  always_comb begin
    we = 1'b0;
    wa = ra0_r;
    wd = rd_q;
    unique case (state_r)
      ST_TICK: begin
        we = rv0_r;
        wa = ra0_r;
        wd = rd_q;
        if (rd_q.count != '0) begin
          wd.count = rd_q.count - ibt_pkg::COUNT_BITS'(1);
        end
      end
      ST_UPD: begin
        we       = 1'b1;
        wa       = m_idx_r;
        wd.ident = m_ident_r;
        wd.count = sat_count;
        wd.box   = cand_box_r;
      end
      ST_INS: begin
        we       = !full;
        wa       = fill_r[AW-1:0];
        wd.ident = new_id;
        wd.count = ibt_pkg::COUNT_NEW;
        wd.box   = cand_box_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_data.op == ibt_pkg::OP_CANDIDATE) ? ST_PREP : ST_TICK;
        end
      end
      ST_TICK: begin
        if (!more && !rv0_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PREP: state_nxt = ST_SCAN;
      ST_SCAN: begin
        priority if (iou_st.hit) begin
          state_nxt = ST_UPD;
        end else if (!more && !rv0_r && !iou_st.busy) begin
          state_nxt = ST_INS;
        end
      end
      ST_UPD:  state_nxt = ST_IDLE;
      ST_INS:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pad_r       <= ibt_pkg::BOX_PADDING_RST;
      frame_w_r   <= ibt_pkg::FRAME_WIDTH_RST;
      frame_h_r   <= ibt_pkg::FRAME_HEIGHT_RST;
      limit_r     <= ibt_pkg::HISTORY_LIMIT_RST;
      fill_r      <= '0;
      highest_r   <= '0;
      iss_r       <= '0;
      rv0_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rv0_r       <= issue;
      out_valid_r <= (state_r == ST_UPD) || (state_r == ST_INS);
      if (accept) begin
        iss_r <= '0;
      end else if (issue) begin
        iss_r <= iss_r + CW'(1);
      end
      if ((state_r == ST_INS) && !full) begin
        fill_r    <= fill_r + CW'(1);
        highest_r <= new_id;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          ibt_pkg::CFG_BOX_PADDING:   pad_r     <= cfg_wdata[ibt_pkg::PAD_BITS-1:0];
          ibt_pkg::CFG_FRAME_WIDTH:   frame_w_r <= cfg_wdata;
          ibt_pkg::CFG_FRAME_HEIGHT:  frame_h_r <= cfg_wdata;
          ibt_pkg::CFG_HISTORY_LIMIT: limit_r   <= cfg_wdata[ibt_pkg::LIMIT_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ra0_r <= rd_addr;
    if (accept) begin
      cand_box_r <= prep_box;
    end
    if (state_r == ST_PREP) begin
      cand_area_r <= cand_dx * cand_dy;
    end
    if (iou_st.hit && (state_r == ST_SCAN)) begin
      m_idx_r   <= hit_idx;
      m_ident_r <= hit_ident;
      m_count_r <= hit_count;
    end
    unique case (state_r)
      ST_UPD: begin
        out_data_r.region_id  <= m_ident_r;
        out_data_r.matched    <= 1'b1;
        out_data_r.table_full <= 1'b0;
      end
      ST_INS: begin
        out_data_r.region_id  <= full ? '0 : new_id;
        out_data_r.matched    <= 1'b0;
        out_data_r.table_full <= full;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(TABLE_DEPTH))
    else $error("fill level beyond table depth");

  a_ident_live: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != '0) |-> (highest_r != '0))
    else $error("filled table with zero highest identifier");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.matched && out_data.table_full)
                  && (out_data.table_full == (out_data.region_id == '0)))
    else $error("inconsistent result flags");

  a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !rv0_r && !iou_st.busy)
    else $error("scan activity while idle");

  a_result_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE) && $past(state_r == ST_UPD || state_r == ST_INS))
    else $error("result without write-back");

endmodule
